// ===== sv/flph_pkg.sv =====
// ----------------------------------------------------------------------------
// flph_pkg
// Shared types and constants for the linear-probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package flph_pkg;

   // Request operations.
   localparam logic [1:0] FUNC_GET    = 2'd0;
   localparam logic [1:0] FUNC_SET    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // Slot marks.
   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_USED  = 2'd1;
   localparam logic [1:0] MARK_TOMB  = 2'd2;

   // FNV-1a 64-bit constants.
   localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
   localparam logic [63:0] FNV_MULT  = 64'd1099511628211;

   // Load limit register.
   localparam int         LIMIT_W          = 11;
   localparam logic [10:0] LOAD_LIMIT_RESET = 11'd716;

   // Number of bytes hashed per key.
   localparam int KEY_BYTES = 8;

   // Request as it travels from the front to the back.
   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key;
      logic [63:0] write_value;
   } job_type;

endpackage

`default_nettype wire

// ===== sv/flph_req_if.sv =====
// ----------------------------------------------------------------------------
// flph_req_if
// Request channel: valid/ready handshake with operation, key and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface flph_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [63:0] key;
   logic [63:0] write_value;

   modport source (output valid, output func, output key, output write_value, input ready);
   modport sink (input valid, input func, input key, input write_value, output ready);
endinterface

`default_nettype wire

// ===== sv/flph_rsp_if.sv =====
// ----------------------------------------------------------------------------
// flph_rsp_if
// Response channel: valid/ready handshake with status and read value.
// ----------------------------------------------------------------------------
`default_nettype none

interface flph_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] read_value;

   modport source (output valid, output status, output read_value, input ready);
   modport sink (input valid, input status, input read_value, output ready);
endinterface

`default_nettype wire

// ===== sv/fnv_linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// fnv_linear_probe_hash_table
// Fixed-capacity key-value table with FNV-1a hashing and linear probing.
// ----------------------------------------------------------------------------
// Each request passes the front (capture, eight FNV-1a rounds on one narrow
// multiplier, hand-off), then the probe engine, which visits one slot per
// cycle (set by the single read port of the slot memories, at most CAPACITY
// slots) and holds on the final slot while the response is stalled. The front
// hashes the next request while the back probes, so a new request can be taken
// before the last one is through. After reset the table clears its slot marks
// before the probe engine takes the first request; the load limit
// register may be written at any time the block is idle.
`default_nettype none

module fnv_linear_probe_hash_table #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   flph_req_if.sink                           req_ch,
   flph_rsp_if.source                         rsp_ch,
   input  wire logic                          csr_write_en,
   input  wire logic [flph_pkg::LIMIT_W-1:0]  csr_write_data
);
   import flph_pkg::*;

   localparam int HASH_W = $clog2(CAPACITY);
   localparam int JOB_W  = $bits(job_type) + HASH_W;

   logic [LIMIT_W-1:0] load_limit_ff;
   job_type            front_job;
   logic [HASH_W-1:0]  front_home;
   logic               front_valid;
   logic               front_ready;
   logic [JOB_W-1:0]   queue_out;
   logic               queue_valid;
   logic               queue_ready;
   job_type            back_job;
   logic [HASH_W-1:0]  back_home;

   // Load limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff <= LOAD_LIMIT_RESET;
      end else if (csr_write_en) begin
         load_limit_ff <= csr_write_data;
      end
   end

   flph_front #(.HASH_W(HASH_W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .job_out   (front_job),
      .home_out  (front_home),
      .job_valid (front_valid),
      .job_ready (front_ready)
   );

   flph_queue #(.WIDTH(JOB_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  ({front_job, front_home}),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_out)
   );

   assign back_job  = queue_out[JOB_W-1:HASH_W];
   assign back_home = queue_out[HASH_W-1:0];

   flph_back #(.CAPACITY(CAPACITY)) u_back (
      .clock      (clock),
      .reset      (reset),
      .load_limit (load_limit_ff),
      .job_valid  (queue_valid),
      .job_ready  (queue_ready),
      .job_in     (back_job),
      .home_in    (back_home),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== sv/flph_front.sv =====
// ----------------------------------------------------------------------------
// flph_front
// Accepts requests and computes the home slot with an iterative FNV-1a unit.
// ----------------------------------------------------------------------------
`default_nettype none

module flph_front #(
   parameter int HASH_W = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   flph_req_if.sink               req_ch,
   output flph_pkg::job_type      job_out,
   output logic [HASH_W-1:0]      home_out,
   output logic                   job_valid,
   input  wire logic              job_ready
);
   import flph_pkg::*;

   localparam int STEP_W = $clog2(KEY_BYTES);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(KEY_BYTES - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_in;
   job_type           job_ff;
   logic [7:0]        byte_sel;
   logic [HASH_W-1:0] mix;
   logic [2*HASH_W-1:0] product;

   // Only the low bits of the hash reach the slot index, and the low bits of
   // a product depend only on the low bits of its operands.
   assign byte_sel = job_ff.key[8*step_ff +: 8];
   assign mix      = hash_ff ^ HASH_W'(byte_sel);
   assign product  = {{HASH_W{1'b0}}, mix} * {{HASH_W{1'b0}}, FNV_MULT[HASH_W-1:0]};
   assign hash_in  = product[HASH_W-1:0];

   // Request capture, one hash round per cycle, then hand-off to the queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (!busy_ff && req_ch.valid) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff && !done_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            done_ff <= 1'b1;
         end
      end else if (done_ff && job_ready) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!busy_ff && req_ch.valid) begin
         job_ff.func        <= req_ch.func;
         job_ff.key         <= req_ch.key;
         job_ff.write_value <= req_ch.write_value;
         hash_ff            <= FNV_BASIS[HASH_W-1:0];
      end else if (busy_ff && !done_ff) begin
         hash_ff <= hash_in;
      end
   end

   assign req_ch.ready = !busy_ff;
   assign job_valid    = done_ff;
   assign job_out      = job_ff;
   assign home_out     = hash_ff;

   // A job is offered only after all rounds of the hash have run.
   assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(step_ff) == LAST_STEP)
      else $error("hash handed off early");
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> busy_ff)
      else $error("done without a request");
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !done_ff) |=> $stable(job_ff))
      else $error("request changed during hashing");

endmodule

`default_nettype wire

// ===== sv/flph_queue.sv =====
// ----------------------------------------------------------------------------
// flph_queue
// Two-entry queue that decouples the hashing front from the probing back.
// ----------------------------------------------------------------------------
`default_nettype none

module flph_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/flph_back.sv =====
// ----------------------------------------------------------------------------
// flph_back
// Probe engine: walks the slot memories one slot per cycle, holding on the
// final slot while the response is stalled, and applies the request, then registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module flph_back #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [flph_pkg::LIMIT_W-1:0]   load_limit,
   input  wire logic                           job_valid,
   output logic                                job_ready,
   input  wire flph_pkg::job_type              job_in,
   input  wire logic [$clog2(CAPACITY)-1:0]    home_in,
   flph_rsp_if.source                          rsp_ch
);
   import flph_pkg::*;

   localparam int HASH_W  = $clog2(CAPACITY);
   localparam int COUNT_W = HASH_W + 1;
   localparam int SUM_W   = (COUNT_W + 1 > LIMIT_W) ? COUNT_W + 1 : LIMIT_W;
   localparam logic [HASH_W-1:0] LAST_SLOT = '1;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PROBE} state_type;

   state_type          state_ff;
   logic [HASH_W-1:0]  slot_ff;
   logic [HASH_W-1:0]  probes_ff;
   logic [HASH_W-1:0]  tomb_at_ff;
   logic               have_tomb_ff;
   job_type            job_ff;
   logic [COUNT_W-1:0] live_ff;
   logic [COUNT_W-1:0] tomb_cnt_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [63:0]        rsp_value_ff;

   // Slot memories and their registered read data.
   logic [1:0]  mark_mem [CAPACITY];
   logic [63:0] key_mem  [CAPACITY];
   logic [63:0] val_mem  [CAPACITY];
   logic [1:0]  mark_rd_ff;
   logic [63:0] key_rd_ff;
   logic [63:0] val_rd_ff;

   logic [HASH_W-1:0] rd_addr;
   logic              mark_we;
   logic [HASH_W-1:0] mark_wa;
   logic [1:0]        mark_wd;
   logic              kv_we;
   logic [HASH_W-1:0] kv_wa;

   // Probe decisions.
   logic              out_free;
   logic              is_empty;
   logic              is_tomb;
   logic              key_hit;
   logic              last_probe;
   logic              have_eff;
   logic [HASH_W-1:0] tomb_eff;
   logic [SUM_W-1:0]  occupied;
   logic              under_limit;
   logic              finish;
   logic              go;
   logic [1:0]        fin_status;
   logic [63:0]       fin_value;
   logic              fill_tomb;
   logic              fill_empty;
   logic              update_hit;
   logic              remove_hit;

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign is_empty    = (mark_rd_ff == MARK_EMPTY);
   assign is_tomb     = (mark_rd_ff != MARK_EMPTY) && (mark_rd_ff != MARK_USED);
   assign key_hit     = (mark_rd_ff == MARK_USED) && (key_rd_ff == job_ff.key);
   assign last_probe  = (probes_ff == LAST_SLOT);
   assign have_eff    = have_tomb_ff || is_tomb;
   assign tomb_eff    = have_tomb_ff ? tomb_at_ff : slot_ff;
   assign occupied    = SUM_W'(live_ff) + SUM_W'(tomb_cnt_ff);
   assign under_limit = occupied < SUM_W'(load_limit);

   // Outcome of the slot under inspection.
   always_comb begin
      finish     = 1'b0;
      fin_status = ST_MISSING;
      fin_value  = '0;
      fill_tomb  = 1'b0;
      fill_empty = 1'b0;
      update_hit = 1'b0;
      remove_hit = 1'b0;
      case (job_ff.func)
         FUNC_GET: begin
            if (key_hit) begin
               finish     = 1'b1;
               fin_status = ST_DONE;
               fin_value  = val_rd_ff;
            end else if (is_empty || last_probe) begin
               finish = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (key_hit) begin
               finish     = 1'b1;
               fin_status = ST_DONE;
               fin_value  = val_rd_ff;
               remove_hit = 1'b1;
            end else if (is_empty || last_probe) begin
               finish = 1'b1;
            end
         end
         FUNC_SET: begin
            if (key_hit) begin
               finish     = 1'b1;
               fin_status = ST_DONE;
               update_hit = 1'b1;
            end else if (is_empty || last_probe) begin
               finish = 1'b1;
               if (have_eff) begin
                  fin_status = ST_DONE;
                  fill_tomb  = 1'b1;
               end else if (is_empty && under_limit) begin
                  fin_status = ST_DONE;
                  fill_empty = 1'b1;
               end else begin
                  fin_status = ST_FULL;
               end
            end
         end
         default: begin
            finish = 1'b1;
         end
      endcase
   end

   assign go = (state_ff == S_PROBE) && finish && out_free;

   // Memory write controls.
   always_comb begin
      mark_we = 1'b0;
      mark_wa = slot_ff;
      mark_wd = MARK_EMPTY;
      kv_we   = 1'b0;
      kv_wa   = slot_ff;
      if (state_ff == S_CLEAR) begin
         mark_we = 1'b1;
         mark_wa = probes_ff;
      end else if (go) begin
         if (remove_hit) begin
            mark_we = 1'b1;
            mark_wd = MARK_TOMB;
         end else if (update_hit || fill_empty) begin
            kv_we   = 1'b1;
            mark_we = fill_empty;
            mark_wd = MARK_USED;
         end else if (fill_tomb) begin
            kv_we   = 1'b1;
            kv_wa   = tomb_eff;
            mark_we = 1'b1;
            mark_wa = tomb_eff;
            mark_wd = MARK_USED;
         end
      end
   end

   // Read address: the home slot on dispatch, the next slot while probing.
   always_comb begin
      rd_addr = slot_ff;
      if (state_ff == S_IDLE) begin
         rd_addr = home_in;
      end else if (state_ff == S_PROBE && !finish) begin
         rd_addr = slot_ff + 1'b1;
      end
   end

   assign job_ready = (state_ff == S_IDLE);

   // Slot memories.
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      mark_rd_ff <= mark_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (kv_we) begin
         key_mem[kv_wa] <= job_ff.key;
         val_mem[kv_wa] <= job_ff.write_value;
      end
      key_rd_ff <= key_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
   end

   // Sequencer, counters and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         probes_ff    <= '0;
         live_ff      <= '0;
         tomb_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && !go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               probes_ff <= probes_ff + 1'b1;
               if (probes_ff == LAST_SLOT) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (job_valid) begin
                  job_ff       <= job_in;
                  slot_ff      <= home_in;
                  probes_ff    <= '0;
                  have_tomb_ff <= 1'b0;
                  state_ff     <= S_PROBE;
               end
            end
            S_PROBE: begin
               if (go) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= fin_status;
                  rsp_value_ff  <= fin_value;
                  state_ff      <= S_IDLE;
                  if (remove_hit) begin
                     live_ff     <= live_ff - 1'b1;
                     tomb_cnt_ff <= tomb_cnt_ff + 1'b1;
                  end else if (fill_tomb) begin
                     live_ff     <= live_ff + 1'b1;
                     tomb_cnt_ff <= tomb_cnt_ff - 1'b1;
                  end else if (fill_empty) begin
                     live_ff <= live_ff + 1'b1;
                  end
               end else if (!finish) begin
                  slot_ff   <= slot_ff + 1'b1;
                  probes_ff <= probes_ff + 1'b1;
                  if (is_tomb && !have_tomb_ff) begin
                     have_tomb_ff <= 1'b1;
                     tomb_at_ff   <= slot_ff;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.read_value = rsp_value_ff;

   // Occupied slots never exceed the table size.
   assert property (@(posedge clock) disable iff (reset)
      (SUM_W'(live_ff) + SUM_W'(tomb_cnt_ff)) <= SUM_W'(CAPACITY))
      else $error("slot counts exceed capacity");
   // No response appears and no job is taken while the marks are being cleared.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff && !job_ready)
      else $error("activity during clearing pass");
   // A stalled response blocks every table update.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE && !out_free) |-> !kv_we && !mark_we)
      else $error("table written while response stalled");
   // A fill of an empty slot advances the live count by one.
   assert property (@(posedge clock) disable iff (reset)
      (go && fill_empty) |=> live_ff == $past(live_ff) + 1'b1)
      else $error("live count not advanced on fill");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the linear-probing hash table against a behavioral table model.
// Directed transactions cover the edge cases, then random get, set and remove
// traffic on a small key pool runs under several load limits.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import flph_pkg::*;

   localparam int SLOTS = 1024;
   localparam int MAX_CYCLES = 6000000;
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] read_value;
   } reply_type;

   typedef struct {
      logic [1:0]  func;
      logic [63:0] key;
      logic [63:0] write_value;
      bit          typed;
      logic [1:0]  status;
      logic [63:0] read_value;
   } row_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [LIMIT_W-1:0] csr_write_data;

   flph_req_if req_ch ();
   flph_rsp_if rsp_ch ();

   fnv_linear_probe_hash_table uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // Shadow copy of the table.
   logic [63:0] tbl_keys [SLOTS];
   logic [63:0] tbl_values [SLOTS];
   logic [1:0]  tbl_marks [SLOTS];
   int unsigned live_slots;
   int unsigned dead_slots;
   int unsigned limit_now;

   reply_type pending_replies[$];
   int mismatch_count;
   int cycle_count;
   logic [63:0] key_pool [32];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // FNV-1a over the key bytes, low byte first, masked to the table size.
   function automatic int unsigned slot_of(logic [63:0] key);
      logic [63:0] h;
      h = FNV_BASIS;
      for (int b = 0; b < KEY_BYTES; b++) begin
         h = h ^ {56'd0, key[b*8 +: 8]};
         h = h * FNV_MULT;
      end
      return 32'(h[9:0]);
   endfunction

   // Applies one transaction to the shadow table and returns its reply.
   function automatic reply_type table_apply(logic [1:0] func, logic [63:0] key,
                                             logic [63:0] wval);
      reply_type r;
      int unsigned s;
      int unsigned tomb_at;
      bit have_tomb;
      bit have_empty;
      bit found;
      r.status = ST_MISSING;
      r.read_value = '0;
      s = slot_of(key);
      have_tomb = 0;
      have_empty = 0;
      found = 0;
      tomb_at = 0;
      for (int n = 0; n < SLOTS; n++) begin
         if (tbl_marks[s] == MARK_EMPTY) begin
            have_empty = 1;
            break;
         end
         if (tbl_marks[s] == MARK_USED && tbl_keys[s] == key) begin
            found = 1;
            break;
         end
         if (tbl_marks[s] != MARK_USED && !have_tomb) begin
            have_tomb = 1;
            tomb_at = s;
         end
         s = (s + 1) % SLOTS;
      end
      if (func == FUNC_GET) begin
         if (found) begin
            r.status = ST_DONE;
            r.read_value = tbl_values[s];
         end
      end else if (func == FUNC_REMOVE) begin
         if (found) begin
            r.status = ST_DONE;
            r.read_value = tbl_values[s];
            tbl_marks[s] = MARK_TOMB;
            live_slots--;
            dead_slots++;
         end
      end else if (func == FUNC_SET) begin
         if (found) begin
            tbl_values[s] = wval;
            r.status = ST_DONE;
         end else if (have_tomb) begin
            tbl_keys[tomb_at] = key;
            tbl_values[tomb_at] = wval;
            tbl_marks[tomb_at] = MARK_USED;
            dead_slots--;
            live_slots++;
            r.status = ST_DONE;
         end else if (have_empty && live_slots + dead_slots < limit_now) begin
            tbl_keys[s] = key;
            tbl_values[s] = wval;
            tbl_marks[s] = MARK_USED;
            live_slots++;
            r.status = ST_DONE;
         end else begin
            r.status = ST_FULL;
         end
      end
      return r;
   endfunction

   // Receiver stalls on a rotating pattern, randomly relieved, with stall-free phases.
   logic [15:0] stall_pattern;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_pattern <= 16'b1011_0111_1110_0101;
      end else begin
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
         if (cycle_count[12]) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= stall_pattern[15] | ($urandom_range(0, 3) == 0);
         end
      end
   end

   // Compare every accepted response with the oldest pending reply.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected response: status %0d value %h",
                        rsp_ch.status, rsp_ch.read_value);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.read_value !== want.read_value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Response mismatch: expected %0d/%h, got %0d/%h",
                           want.status, want.read_value, rsp_ch.status,
                           rsp_ch.read_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("Timeout at cycle %0d", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Sends one transaction, queues its predicted reply and checks typed rows against it.
   task automatic send(logic [1:0] func, logic [63:0] key, logic [63:0] wval,
                       bit typed, logic [1:0] tst, logic [63:0] tval);
      reply_type r;
      r = table_apply(func, key, wval);
      if (typed && (r.status !== tst || r.read_value !== tval)) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Table row disagrees with prediction for key %h", key);
      end
      pending_replies.push_back(r);
      req_ch.valid <= 1'b1;
      req_ch.func <= func;
      req_ch.key <= key;
      req_ch.write_value <= wval;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle_gap(int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(int unsigned value);
      csr_write_en <= 1'b1;
      csr_write_data <= value[LIMIT_W-1:0];
      limit_now = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   row_type directed_rows[$];

   function automatic row_type mk(logic [1:0] f, logic [63:0] k, logic [63:0] v,
                                  bit t, logic [1:0] st, logic [63:0] rv);
      row_type r;
      r.func = f; r.key = k; r.write_value = v;
      r.typed = t; r.status = st; r.read_value = rv;
      return r;
   endfunction

   initial begin
      int burst;
      int limits [6];
      logic [1:0] f;
      logic [63:0] k;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_GET;
      req_ch.key = '0;
      req_ch.write_value = '0;
      rsp_ch.ready = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      live_slots = 0;
      dead_slots = 0;
      limit_now = 32'(LOAD_LIMIT_RESET);
      for (int i = 0; i < SLOTS; i++) begin
         tbl_marks[i] = MARK_EMPTY;
         tbl_keys[i] = '0;
         tbl_values[i] = '0;
      end
      for (int i = 0; i < 32; i++) key_pool[i] = rand64();
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: misses on an empty table, extremes, every operation,
      // replacement, tombstone reuse and an unknown operation.
      directed_rows.push_back(mk(FUNC_GET, 64'd0, 64'd0, 1'b1, ST_MISSING, 64'd0));
      directed_rows.push_back(mk(FUNC_REMOVE, '1, 64'd0, 1'b1, ST_MISSING, 64'd0));
      directed_rows.push_back(mk(FUNC_UNKNOWN, '1, '1, 1'b1, ST_MISSING, 64'd0));
      directed_rows.push_back(mk(FUNC_SET, 64'd0, '1, 1'b1, ST_DONE, 64'd0));
      directed_rows.push_back(mk(FUNC_SET, '1, 64'd0, 1'b1, ST_DONE, 64'd0));
      directed_rows.push_back(mk(FUNC_GET, 64'd0, 64'd5, 1'b1, ST_DONE, '1));
      directed_rows.push_back(mk(FUNC_GET, '1, 64'd0, 1'b1, ST_DONE, 64'd0));
      directed_rows.push_back(mk(FUNC_SET, 64'd0, 64'h0123_4567_89ab_cdef, 1'b0,
                                 ST_DONE, 64'd0));
      directed_rows.push_back(mk(FUNC_GET, 64'd0, 64'd0, 1'b0, ST_DONE, 64'd0));
      directed_rows.push_back(mk(FUNC_REMOVE, 64'd0, 64'd0, 1'b0, ST_DONE, 64'd0));
      directed_rows.push_back(mk(FUNC_GET, 64'd0, 64'd0, 1'b1, ST_MISSING, 64'd0));
      directed_rows.push_back(mk(FUNC_REMOVE, 64'd0, 64'd0, 1'b1, ST_MISSING, 64'd0));
      directed_rows.push_back(mk(FUNC_SET, 64'd0, 64'h8000_0000_0000_0001, 1'b0,
                                 ST_DONE, 64'd0));
      directed_rows.push_back(mk(FUNC_UNKNOWN, 64'd0, 64'd0, 1'b1, ST_MISSING, 64'd0));
      directed_rows.push_back(mk(FUNC_REMOVE, '1, 64'd0, 1'b1, ST_DONE, 64'd0));
      directed_rows.push_back(mk(FUNC_SET, 64'h5555_aaaa_5555_aaaa, '1, 1'b0,
                                 ST_DONE, 64'd0));
      foreach (directed_rows[i])
         send(directed_rows[i].func, directed_rows[i].key, directed_rows[i].write_value,
              directed_rows[i].typed, directed_rows[i].status, directed_rows[i].read_value);

      // Hold off until every response is back, then walk the load limits.
      wait_drained();
      limits = '{0, 1, 3, 40, 2047, int'(LOAD_LIMIT_RESET)};
      foreach (limits[p]) begin
         write_limit(limits[p]);
         for (int n = 0; n < 270; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++, n++) begin
               f = $urandom_range(0, 9) < 5 ? FUNC_SET :
                   ($urandom_range(0, 1) ? FUNC_GET : FUNC_REMOVE);
               if ($urandom_range(0, 19) == 0) f = FUNC_UNKNOWN;
               k = ($urandom_range(0, 7) == 0) ? rand64()
                   : key_pool[$urandom_range(0, p == 4 ? 31 : 15)];
               send(f, k, rand64(), 1'b0, ST_DONE, 64'd0);
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 15));
         end
         wait_drained();
      end

      // Clean out the pool with a remove of every key.
      for (int i = 0; i < 32; i++) send(FUNC_REMOVE, key_pool[i], '0, 1'b0, ST_DONE, 64'd0);
      wait_drained();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

`default_nettype wire
